// ----- sv/moving_average_plateau_detector_macros.svh -----
// Assertion macros for the moving-average plateau detector.
`ifndef MOVING_AVERAGE_PLATEAU_DETECTOR_MACROS_SVH
`define MOVING_AVERAGE_PLATEAU_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

`define MAPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mapd: invariant violated");

`define MAPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mapd: implication violated");

`define MAPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mapd: next-cycle implication violated");

`else

`define MAPD_ASSERT(lbl, clk, rst_n, prop)

`define MAPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define MAPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/mapd_pkg.sv -----
// Types, constants and microcode program of the moving-average plateau detector.
`timescale 1ns / 1ps

package mapd_pkg;

    localparam int SCORE_BITS       = 32;
    localparam int K_MAX_DEF        = 8;
    localparam int JUMP_BITS        = 16;
    localparam int TOL_BITS         = 16;
    localparam int WLEN_BITS        = 4;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_IDX_BITS     = 2;
    localparam int WINDOW_LEN_RESET = 3;
    localparam int MUL_STEPS        = TOL_BITS / 2;
    localparam int DIV_STEPS        = JUMP_BITS;

    localparam logic [JUMP_BITS-1:0] JUMP_SAT = 16'h7FFF;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MORE_IS_BETTER = 2'd2;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic                  clear_history;
    } t_in_word;

    typedef struct packed {
        logic                        stop;
        logic                        history_ready;
        logic signed [JUMP_BITS-1:0] jump;
    } t_out_word;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE      = 4'd0;
    localparam t_pc PC_SETUP     = 4'd1;
    localparam t_pc PC_SUM_RD    = 4'd2;
    localparam t_pc PC_SUM_LOOP  = 4'd3;
    localparam t_pc PC_REF       = 4'd4;
    localparam t_pc PC_MUL       = 4'd5;
    localparam t_pc PC_THR       = 4'd6;
    localparam t_pc PC_SLIDE_RD  = 4'd7;
    localparam t_pc PC_SLIDE_SUB = 4'd8;
    localparam t_pc PC_SLIDE_ADD = 4'd9;
    localparam t_pc PC_DIV_INIT  = 4'd10;
    localparam t_pc PC_DIV       = 4'd11;
    localparam t_pc PC_RESULT    = 4'd12;
    localparam t_pc PC_EMPTY     = 4'd13;

    typedef logic [2:0] t_acc_op;
    localparam t_acc_op ACC_HOLD   = 3'd0;
    localparam t_acc_op ACC_CLEAR  = 3'd1;
    localparam t_acc_op ACC_ADD    = 3'd2;
    localparam t_acc_op ACC_SUB    = 3'd3;
    localparam t_acc_op ACC_ADDCMP = 3'd4;

    typedef logic [1:0] t_rd_op;
    localparam t_rd_op RD_NONE = 2'd0;
    localparam t_rd_op RD_LO   = 2'd1;
    localparam t_rd_op RD_HI   = 2'd2;

    typedef logic [1:0] t_idx_op;
    localparam t_idx_op IDX_HOLD   = 2'd0;
    localparam t_idx_op IDX_INIT   = 2'd1;
    localparam t_idx_op IDX_LO_CLR = 2'd2;

    typedef logic [2:0] t_cnt_op;
    localparam t_cnt_op CNT_HOLD     = 3'd0;
    localparam t_cnt_op CNT_LOAD_K   = 3'd1;
    localparam t_cnt_op CNT_LOAD_MUL = 3'd2;
    localparam t_cnt_op CNT_LOAD_DIV = 3'd3;
    localparam t_cnt_op CNT_DEC      = 3'd4;

    typedef logic [2:0] t_aux_op;
    localparam t_aux_op AUX_NONE       = 3'd0;
    localparam t_aux_op AUX_REF_LOAD   = 3'd1;
    localparam t_aux_op AUX_MUL_STEP   = 3'd2;
    localparam t_aux_op AUX_THR_SET    = 3'd3;
    localparam t_aux_op AUX_DIV_INIT   = 3'd4;
    localparam t_aux_op AUX_DIV_STEP   = 3'd5;
    localparam t_aux_op AUX_OUT_RESULT = 3'd6;
    localparam t_aux_op AUX_OUT_EMPTY  = 3'd7;

    typedef logic [2:0] t_jmp_cond;
    localparam t_jmp_cond JC_NEXT      = 3'd0;
    localparam t_jmp_cond JC_ALWAYS    = 3'd1;
    localparam t_jmp_cond JC_INPUT     = 3'd2;
    localparam t_jmp_cond JC_NOT_READY = 3'd3;
    localparam t_jmp_cond JC_CNT_MORE  = 3'd4;
    localparam t_jmp_cond JC_OUT_FREE  = 3'd5;

    typedef struct packed {
        logic      take_input;
        t_acc_op   acc_op;
        t_rd_op    rd_op;
        t_idx_op   idx_op;
        t_cnt_op   cnt_op;
        t_aux_op   aux_op;
        t_jmp_cond cond;
        logic      hold;
        t_pc       target;
    } t_ctl_word;

    // A taken condition loads the target; otherwise the step counter advances or holds.
    function automatic t_ctl_word ucode(input t_pc pc);
        t_ctl_word w;
        w = '0;
        case (pc)
            PC_IDLE: begin
                w.take_input = 1'b1;
                w.cond       = JC_INPUT;
                w.hold       = 1'b1;
                w.target     = PC_SETUP;
            end
            PC_SETUP: begin
                w.acc_op = ACC_CLEAR;
                w.idx_op = IDX_INIT;
                w.cnt_op = CNT_LOAD_K;
                w.cond   = JC_NOT_READY;
                w.target = PC_EMPTY;
            end
            PC_SUM_RD: begin
                w.rd_op = RD_LO;
            end
            PC_SUM_LOOP: begin
                w.acc_op = ACC_ADD;
                w.rd_op  = RD_LO;
                w.cnt_op = CNT_DEC;
                w.cond   = JC_CNT_MORE;
                w.target = PC_SUM_LOOP;
            end
            PC_REF: begin
                w.aux_op = AUX_REF_LOAD;
                w.idx_op = IDX_LO_CLR;
                w.cnt_op = CNT_LOAD_MUL;
            end
            PC_MUL: begin
                w.aux_op = AUX_MUL_STEP;
                w.cnt_op = CNT_DEC;
                w.cond   = JC_CNT_MORE;
                w.target = PC_MUL;
            end
            PC_THR: begin
                w.aux_op = AUX_THR_SET;
                w.cnt_op = CNT_LOAD_K;
            end
            PC_SLIDE_RD: begin
                w.rd_op = RD_LO;
            end
            PC_SLIDE_SUB: begin
                w.acc_op = ACC_SUB;
                w.rd_op  = RD_HI;
            end
            PC_SLIDE_ADD: begin
                w.acc_op = ACC_ADDCMP;
                w.rd_op  = RD_LO;
                w.cnt_op = CNT_DEC;
                w.cond   = JC_CNT_MORE;
                w.target = PC_SLIDE_SUB;
            end
            PC_DIV_INIT: begin
                w.aux_op = AUX_DIV_INIT;
                w.cnt_op = CNT_LOAD_DIV;
            end
            PC_DIV: begin
                w.aux_op = AUX_DIV_STEP;
                w.cnt_op = CNT_DEC;
                w.cond   = JC_CNT_MORE;
                w.target = PC_DIV;
            end
            PC_RESULT: begin
                w.aux_op = AUX_OUT_RESULT;
                w.cond   = JC_OUT_FREE;
                w.hold   = 1'b1;
                w.target = PC_IDLE;
            end
            PC_EMPTY: begin
                w.aux_op = AUX_OUT_EMPTY;
                w.cond   = JC_OUT_FREE;
                w.hold   = 1'b1;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = JC_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/moving_average_plateau_detector.sv -----
// Top level of the moving-average plateau detector with its microcoded datapath.
// Each accepted word appends one Q16.16 score to a history of the last 2*K_MAX scores and
// yields exactly one result word. Once more than 2k scores are held, a microcode program
// sums the oldest window, slides it k times over the history memory (one read port) while
// checking each window against the tolerance threshold, and divides the first-minus-last
// difference by the first-plus-last sum to form the Q1.15 jump. With k the effective window
// length, a word whose history is ready runs the reference sum, the radix-4 tolerance
// multiply, the k slides (two memory reads each), the restoring divider and the control
// steps. A word whose history is not yet ready yields an empty result word. The next word
// is accepted while the previous result still waits.
`timescale 1ns / 1ps
`include "moving_average_plateau_detector_macros.svh"

module moving_average_plateau_detector #(
    parameter int K_MAX = mapd_pkg::K_MAX_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mapd_pkg::t_in_word                    i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mapd_pkg::t_out_word                   o_out_word,
    input  logic                                  i_cfg_we,
    input  logic [mapd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mapd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import mapd_pkg::*;

    localparam int DEPTH    = 2 * K_MAX;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int HELD_MAX = 2 * K_MAX + 1;
    localparam int HELD_W   = $clog2(HELD_MAX + 1);
    localparam int K_W      = $clog2(K_MAX + 1);
    localparam int SUM_W    = SCORE_BITS + $clog2(K_MAX + 1);
    localparam int PROD_W   = SUM_W + TOL_BITS;
    localparam int THR_W    = SUM_W + TOL_BITS + 1;
    localparam int REM_W    = SUM_W + 2;
    localparam int CNT_TOP  = (K_MAX > DIV_STEPS) ? K_MAX : DIV_STEPS;
    localparam int CNT_W    = $clog2(CNT_TOP + 1);

    logic [SCORE_BITS-1:0] r_hist [DEPTH];
    logic [SCORE_BITS-1:0] r_rdata;

    logic [WLEN_BITS-1:0]  r_window_len;
    logic [TOL_BITS-1:0]   r_tolerance;
    logic                  r_more_is_better;

    t_pc                   r_pc, n_pc;
    logic [PTR_W-1:0]      r_wp, n_wp;
    logic [HELD_W-1:0]     r_held, n_held;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word, n_out_word;

    logic [SUM_W-1:0]      r_acc, n_acc;
    logic [SUM_W-1:0]      r_ref, n_ref;
    logic [SUM_W+1:0]      r_ref3, n_ref3;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [TOL_BITS-1:0]   r_tsh, n_tsh;
    logic [THR_W-1:0]      r_thr, n_thr;
    logic [PTR_W-1:0]      r_lo, n_lo;
    logic [PTR_W-1:0]      r_hi, n_hi;
    logic [PTR_W-1:0]      r_base, n_base;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_improved, n_improved;
    logic [SUM_W:0]        r_den, n_den;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic                  r_neg, n_neg;
    logic                  r_dz, n_dz;
    logic [JUMP_BITS-1:0]  r_q, n_q;

    t_ctl_word             ctl;
    logic                  in_acc;
    logic                  out_free;
    logic                  out_load;
    logic                  jmp;
    logic [K_W-1:0]        k_eff;
    logic                  hist_ready;
    logic [PTR_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_idx;
    logic [PTR_W:0]        rd_sum;
    logic [PTR_W-1:0]      rd_addr;
    logic [PTR_W:0]        base_sum;
    logic [SUM_W-1:0]      rdata_ext;
    logic [SUM_W-1:0]      acc_add;
    logic [THR_W-1:0]      acc_scaled;
    logic [THR_W-1:0]      ref_scaled;
    logic [SUM_W+1:0]      mul_add;
    logic                  div_ge;
    logic [REM_W-1:0]      div_diff;
    logic [JUMP_BITS-1:0]  q_sat;

    always_comb begin
        ctl      = ucode(r_pc);
        in_acc   = i_in_valid && ctl.take_input;
        out_free = !r_out_valid || !i_out_stall;

        if (32'(r_window_len) > K_MAX) begin
            k_eff = K_W'(K_MAX);
        end else if (r_window_len == '0) begin
            k_eff = K_W'(1);
        end else begin
            k_eff = K_W'(r_window_len);
        end
        hist_ready = r_held >= ((HELD_W'(k_eff) << 1) + HELD_W'(1));

        case (ctl.cond)
            JC_ALWAYS:    jmp = 1'b1;
            JC_INPUT:     jmp = i_in_valid;
            JC_NOT_READY: jmp = !hist_ready;
            JC_CNT_MORE:  jmp = r_cnt != CNT_W'(1);
            JC_OUT_FREE:  jmp = out_free;
            default:      jmp = 1'b0;
        endcase
        if (jmp) begin
            n_pc = ctl.target;
        end else if (ctl.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end

        wr_addr = i_in_word.clear_history ? '0 : r_wp;
        n_wp    = r_wp;
        n_held  = r_held;
        if (in_acc) begin
            n_wp = (wr_addr == PTR_W'(DEPTH - 1)) ? '0 : wr_addr + PTR_W'(1);
            if (i_in_word.clear_history) begin
                n_held = HELD_W'(1);
            end else if (r_held < HELD_W'(HELD_MAX)) begin
                n_held = r_held + HELD_W'(1);
            end
        end

        rd_en  = ctl.rd_op != RD_NONE;
        rd_idx = (ctl.rd_op == RD_HI) ? r_hi : r_lo;
        rd_sum = {1'b0, r_base} + {1'b0, rd_idx};
        if (rd_sum >= (PTR_W+1)'(DEPTH)) begin
            rd_addr = PTR_W'(rd_sum - (PTR_W+1)'(DEPTH));
        end else begin
            rd_addr = rd_sum[PTR_W-1:0];
        end

        // The oldest of the last 2k scores sits 2k slots behind the write pointer.
        base_sum = {1'b0, r_wp} + ((PTR_W+1)'(DEPTH) - ((PTR_W+1)'(k_eff) << 1));
        if (base_sum >= (PTR_W+1)'(DEPTH)) begin
            n_base = PTR_W'(base_sum - (PTR_W+1)'(DEPTH));
        end else begin
            n_base = base_sum[PTR_W-1:0];
        end

        n_lo = r_lo;
        n_hi = r_hi;
        case (ctl.idx_op)
            IDX_INIT: begin
                n_lo = '0;
                n_hi = PTR_W'(k_eff);
            end
            IDX_LO_CLR: begin
                n_lo = '0;
            end
            default: begin
                n_lo = r_lo;
            end
        endcase
        if (ctl.rd_op == RD_LO) begin
            n_lo = r_lo + PTR_W'(1);
        end
        if (ctl.rd_op == RD_HI) begin
            n_hi = r_hi + PTR_W'(1);
        end

        case (ctl.cnt_op)
            CNT_LOAD_K:   n_cnt = CNT_W'(k_eff);
            CNT_LOAD_MUL: n_cnt = CNT_W'(MUL_STEPS);
            CNT_LOAD_DIV: n_cnt = CNT_W'(DIV_STEPS);
            CNT_DEC:      n_cnt = r_cnt - CNT_W'(1);
            default:      n_cnt = r_cnt;
        endcase

        rdata_ext  = SUM_W'(r_rdata);
        acc_add    = r_acc + rdata_ext;
        acc_scaled = THR_W'(acc_add) << TOL_BITS;
        n_improved = r_improved;
        case (ctl.acc_op)
            ACC_CLEAR: n_acc = '0;
            ACC_ADD:   n_acc = acc_add;
            ACC_SUB:   n_acc = r_acc - rdata_ext;
            ACC_ADDCMP: begin
                n_acc = acc_add;
                if (r_more_is_better) begin
                    n_improved = r_improved || (acc_scaled > r_thr);
                end else begin
                    n_improved = r_improved || (acc_scaled < r_thr);
                end
            end
            default:   n_acc = r_acc;
        endcase

        case (r_tsh[TOL_BITS-1 -: 2])
            2'd1:    mul_add = (SUM_W+2)'(r_ref);
            2'd2:    mul_add = {1'b0, r_ref, 1'b0};
            2'd3:    mul_add = r_ref3;
            default: mul_add = '0;
        endcase
        ref_scaled = THR_W'(r_ref) << TOL_BITS;
        div_ge     = r_rem >= REM_W'(r_den);
        div_diff   = div_ge ? (r_rem - REM_W'(r_den)) : r_rem;
        q_sat      = r_q[JUMP_BITS-1] ? JUMP_SAT : r_q;

        n_ref      = r_ref;
        n_ref3     = r_ref3;
        n_prod     = r_prod;
        n_tsh      = r_tsh;
        n_thr      = r_thr;
        n_den      = r_den;
        n_rem      = r_rem;
        n_neg      = r_neg;
        n_dz       = r_dz;
        n_q        = r_q;
        n_out_word = r_out_word;
        out_load   = 1'b0;
        case (ctl.aux_op)
            AUX_REF_LOAD: begin
                n_ref      = r_acc;
                n_ref3     = {2'b00, r_acc} + {1'b0, r_acc, 1'b0};
                n_prod     = '0;
                n_tsh      = r_tolerance;
                n_improved = 1'b0;
            end
            AUX_MUL_STEP: begin
                n_prod = (r_prod << 2) + PROD_W'(mul_add);
                n_tsh  = r_tsh << 2;
            end
            AUX_THR_SET: begin
                if (r_more_is_better) begin
                    n_thr = ref_scaled + THR_W'(r_prod);
                end else begin
                    n_thr = ref_scaled - THR_W'(r_prod);
                end
            end
            AUX_DIV_INIT: begin
                n_den = {1'b0, r_ref} + {1'b0, r_acc};
                n_neg = r_acc > r_ref;
                n_rem = n_neg ? REM_W'(r_acc - r_ref) : REM_W'(r_ref - r_acc);
                n_dz  = n_den == '0;
                n_q   = '0;
            end
            AUX_DIV_STEP: begin
                n_rem = div_diff << 1;
                n_q   = {r_q[JUMP_BITS-2:0], div_ge};
            end
            AUX_OUT_RESULT: begin
                out_load                 = out_free;
                n_out_word.stop          = !r_improved;
                n_out_word.history_ready = 1'b1;
                if (r_dz) begin
                    n_out_word.jump = '0;
                end else if (r_neg) begin
                    n_out_word.jump = -$signed(q_sat);
                end else begin
                    n_out_word.jump = $signed(q_sat);
                end
            end
            AUX_OUT_EMPTY: begin
                out_load                 = out_free;
                n_out_word.stop          = 1'b0;
                n_out_word.history_ready = 1'b0;
                n_out_word.jump          = '0;
            end
            default: begin
                n_q = r_q;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = !ctl.take_input;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc             <= PC_IDLE;
            r_wp             <= '0;
            r_held           <= '0;
            r_out_valid      <= 1'b0;
            r_window_len     <= WLEN_BITS'(WINDOW_LEN_RESET);
            r_tolerance      <= '0;
            r_more_is_better <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_wp        <= n_wp;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LEN:     r_window_len     <= i_cfg_data[WLEN_BITS-1:0];
                    CFG_TOLERANCE:      r_tolerance      <= i_cfg_data[TOL_BITS-1:0];
                    CFG_MORE_IS_BETTER: r_more_is_better <= i_cfg_data[0];
                    default:            r_tolerance      <= r_tolerance;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_ref      <= n_ref;
        r_ref3     <= n_ref3;
        r_prod     <= n_prod;
        r_tsh      <= n_tsh;
        r_thr      <= n_thr;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_cnt      <= n_cnt;
        r_improved <= n_improved;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_dz       <= n_dz;
        r_q        <= n_q;
        if (out_load) begin
            r_out_word <= n_out_word;
        end
        if (ctl.idx_op == IDX_INIT) begin
            r_base <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hist[wr_addr] <= i_in_word.score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_hist[rd_addr];
        end
    end

    `MAPD_ASSERT_NEXT(a_accept_starts_program, i_clk, i_rst_n, in_acc, r_pc == PC_SETUP && o_in_stall)
    `MAPD_ASSERT(a_held_bounded, i_clk, i_rst_n, r_held <= HELD_W'(HELD_MAX))
    `MAPD_ASSERT_IMPL(a_empty_word_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.history_ready, !o_out_word.stop && o_out_word.jump == '0)
    `MAPD_ASSERT_IMPL(a_jump_saturated, i_clk, i_rst_n, o_out_valid, o_out_word.jump != 16'sh8000)

endmodule

// ----- tb/sv/moving_average_plateau_detector_tb.sv -----
// Self-checking testbench for the moving-average plateau detector.
`timescale 1ns / 1ps

module moving_average_plateau_detector_tb;
    import mapd_pkg::*;

    localparam int K_LIMIT        = K_MAX_DEF;
    localparam int HIST_DEPTH     = 2 * K_LIMIT;
    localparam int HELD_MAX       = 2 * K_LIMIT + 1;
    localparam int WORDS_TOTAL    = 1700;
    localparam int IDLE_OFF_AT    = 1450;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    typedef enum {SHAPE_NOISE, SHAPE_FLAT, SHAPE_TREND, SHAPE_CORNER} t_score_shape;

    class plateau_tracker;
        logic [SCORE_BITS-1:0] score_log [HIST_DEPTH];
        logic [3:0]            next_slot;
        int unsigned           held;
        logic [WLEN_BITS-1:0]  win_len;
        logic [TOL_BITS-1:0]   tol;
        logic                  more_better;
        t_out_word             verdicts_due [$];
        int                    errors;
        int                    checked;

        function new();
            foreach (score_log[n]) score_log[n] = '0;
            next_slot   = '0;
            held        = 0;
            win_len     = WLEN_BITS'(WINDOW_LEN_RESET);
            tol         = '0;
            more_better = 1'b0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_WINDOW_LEN:     win_len = data[WLEN_BITS-1:0];
                CFG_TOLERANCE:      tol = data[TOL_BITS-1:0];
                CFG_MORE_IS_BETTER: more_better = data[0];
                default: ;
            endcase
        endfunction

        function t_out_word predict_verdict(t_in_word w);
            int unsigned k;
            int unsigned i;
            int unsigned j;
            logic [63:0] ref_sum;
            logic [63:0] win_sum;
            logic [63:0] last_sum;
            logic [63:0] thr;
            logic [63:0] den;
            logic [63:0] mag;
            logic [63:0] quo;
            logic        improved;
            logic        neg;
            t_out_word   r;
            k = (win_len == 0) ? 1 : (win_len > K_LIMIT) ? K_LIMIT : win_len;
            if (w.clear_history) begin
                held      = 0;
                next_slot = '0;
            end
            score_log[next_slot] = w.score;
            next_slot = next_slot + 4'd1;
            if (held < HELD_MAX) held++;
            r = '0;
            if (held >= 2 * k + 1) begin
                improved = 1'b0;
                ref_sum  = '0;
                last_sum = '0;
                thr      = '0;
                for (i = 0; i <= k; i++) begin
                    win_sum = '0;
                    for (j = 0; j < k; j++) begin
                        win_sum += 64'(score_log[4'((next_slot + HIST_DEPTH - 2 * k + i + j)
                                                    % HIST_DEPTH)]);
                    end
                    if (i == 0) begin
                        ref_sum = win_sum;
                        thr = more_better ? ref_sum * (64'd65536 + 64'(tol))
                                          : ref_sum * (64'd65536 - 64'(tol));
                    end else if (more_better ? ((win_sum << 16) > thr)
                                             : ((win_sum << 16) < thr)) begin
                        improved = 1'b1;
                    end
                    last_sum = win_sum;
                end
                r.history_ready = 1'b1;
                r.stop          = !improved;
                den = ref_sum + last_sum;
                if (den != 0) begin
                    neg = last_sum > ref_sum;
                    mag = neg ? (last_sum - ref_sum) : (ref_sum - last_sum);
                    quo = (mag << 15) / den;
                    if (quo > 64'd32767) quo = 64'd32767;
                    r.jump = neg ? 16'(-quo) : 16'(quo);
                end
            end
            return r;
        endfunction

        function void take_score(t_in_word w);
            verdicts_due = {verdicts_due, predict_verdict(w)};
        endfunction

        task report(string what);
            $display("mismatch at result %0d: %s", checked, what);
            errors++;
        endtask

        task check_verdict(t_out_word got);
            t_out_word want;
            if (verdicts_due.size() == 0) begin
                report($sformatf("result with no word pending: stop=%0b ready=%0b jump=%0d",
                                 got.stop, got.history_ready, got.jump));
                return;
            end
            want = verdicts_due.pop_front();
            if (got.stop !== want.stop)
                report($sformatf("stop %0b, expected %0b", got.stop, want.stop));
            if (got.history_ready !== want.history_ready)
                report($sformatf("history_ready %0b, expected %0b",
                                 got.history_ready, want.history_ready));
            if (got.jump !== want.jump)
                report($sformatf("jump %0d, expected %0d", got.jump, want.jump));
            checked++;
        endtask
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_word                 i_in_word = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_word                o_out_word;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    plateau_tracker board;
    int                words_sent = 0;
    int                quiet_cycles = 0;
    bit                tx_idle_en = 1'b1;
    bit                rx_idle_en = 1'b1;
    bit                hold_off_req = 1'b0;
    logic [31:0]       flat_base;
    logic [31:0]       flat_spread;
    logic [31:0]       trend_level;
    logic [31:0]       trend_step;
    bit                trend_up;

    moving_average_plateau_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) board.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) board.take_score(i_in_word);
            if (o_out_valid && !i_out_stall) board.check_verdict(o_out_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("moving_average_plateau_detector_tb: done, errors");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end else if (rx_idle_en && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task send_word(logic [SCORE_BITS-1:0] score, logic clear);
        i_in_valid <= 1'b1;
        i_in_word  <= '{score: score, clear_history: clear};
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // The wait for a clock edge comes first so that a word accepted at the current edge is on the board.
    task wait_results_in();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task apply_settings(logic [WLEN_BITS-1:0] k, logic [TOL_BITS-1:0] tol, logic more);
        wait_results_in();
        write_reg(CFG_WINDOW_LEN, CFG_DATA_BITS'(k));
        write_reg(CFG_TOLERANCE, CFG_DATA_BITS'(tol));
        write_reg(CFG_MORE_IS_BETTER, CFG_DATA_BITS'(more));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] next_score(t_score_shape shape);
        case (shape)
            SHAPE_FLAT: return flat_base + $urandom_range(0, flat_spread);
            SHAPE_TREND: begin
                trend_level = trend_up ? trend_level + trend_step : trend_level - trend_step;
                return trend_level + $urandom_range(0, 255);
            end
            SHAPE_CORNER: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h0000_0001;
                    3: return 32'h8000_0000;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int           n;
        int           phase;
        int           phase_len;
        t_score_shape shape;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero windows, saturation both ways, equal windows and a history clear.
        write_reg(CFG_SPARE, 16'hFFFF);
        apply_settings(4'd2, 16'd0, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        repeat (4) send_word(32'h0000_0000, 1'b0);
        repeat (4) send_word(32'hFFFF_FFFF, 1'b0);
        repeat (2) send_word(32'h0000_0000, 1'b0);
        send_word(32'h0001_0000, 1'b1);

        // Window length zero acts as one; full tolerance in more-is-better mode.
        apply_settings(4'd0, 16'hFFFF, 1'b1);
        send_word(32'h0005_0000, 1'b1);
        send_word(32'h0007_0000, 1'b0);
        send_word(32'h0003_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);

        phase = 0;
        while (words_sent < WORDS_TOTAL) begin
            case ($urandom_range(0, 5))
                0, 1: shape = SHAPE_FLAT;
                2, 3: shape = SHAPE_TREND;
                4: shape = SHAPE_NOISE;
                default: shape = SHAPE_CORNER;
            endcase
            flat_base   = $urandom;
            flat_spread = ($urandom_range(0, 3) == 0) ? 32'd0
                                                       : (32'd1 << $urandom_range(0, 24)) - 1;
            trend_level = $urandom;
            trend_step  = $urandom_range(0, 32'h0010_0000);
            trend_up    = 1'($urandom_range(0, 1));
            if (words_sent >= IDLE_OFF_AT) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            case ($urandom_range(0, 5))
                0: n = 0;
                1: n = 1;
                2: n = K_LIMIT;
                3: n = 15;
                default: n = $urandom_range(0, 15);
            endcase
            case ($urandom_range(0, 4))
                0: phase_len = 0;
                1: phase_len = 65535;
                2: phase_len = $urandom_range(0, 65535);
                default: phase_len = $urandom_range(0, 3000);
            endcase
            apply_settings(WLEN_BITS'(n), TOL_BITS'(phase_len), 1'($urandom_range(0, 1)));
            if (phase == 3) hold_off_req = 1'b1;
            if ($urandom_range(0, 1) == 0) send_word(next_score(shape), 1'b1);
            phase_len = $urandom_range(30, 110);
            for (n = 0; n < phase_len; n++) begin
                if (tx_idle_en && $urandom_range(0, 4) == 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge i_clk);
                end
                send_word(next_score(shape), $urandom_range(0, 39) == 0);
            end
            phase++;
        end

        wait_results_in();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("moving_average_plateau_detector_tb: done, clean");
        end else begin
            $display("moving_average_plateau_detector_tb: done, errors");
        end
        $finish;
    end

endmodule
